[design/apsp_pkg.sv]
// Shared types and constants for the all-pairs shortest path block.
// Used by the controller, datapath, output queue and top level.
// No dependencies.
package apsp_pkg;

  localparam int REQ_W       = 2;
  localparam int IDX_W       = 6;
  localparam int WEIGHT_W    = 32;
  localparam int SIZE_W      = 7;
  localparam int RES_W       = WEIGHT_W + 1;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // in_tdata field positions
  localparam int ROW_LSB    = REQ_W;
  localparam int COL_LSB    = ROW_LSB + IDX_W;
  localparam int WEIGHT_LSB = COL_LSB + IDX_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2
  } req_type_t;

  // controller to datapath
  typedef struct packed {
    logic req_wr;     // store request weight
    logic req_rd;     // issue read at request address
    logic cnt_clr;    // k = 0, i = 0
    logic via_rd;     // read a(i,k)
    logic via_ld;     // latch a(i,k), j = 0
    logic sweep;      // read a(i,j), a(k,j), advance j
    logic row_next;   // advance i, wrapping into k
    logic push_zero;  // result: value 0, no error
    logic push_err;   // result: value 0, index error
    logic push_rd;    // result: value from read port
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_err;
    logic n_zero;
    logic j_last;
    logic i_last;
    logic k_last;
  } dp_sts_t;

  typedef struct packed {
    logic                index_error;
    logic [WEIGHT_W-1:0] read_value;
  } result_t;

endpackage

[design/apsp_outq.sv]
// Two-entry result queue between the datapath and the output channel.
// Depends on apsp_pkg for the result type.
module apsp_outq
  import apsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [1:0] count_r, count_nxt;
  result_t    head_r, tail_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;
  assign full      = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (count_r)
      2'd0: begin
        if (push) begin
          head_r <= push_data;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_r <= push_data;
        end else if (push) begin
          tail_r <= push_data;
        end
      end
      default: begin
        if (pop) begin
          head_r <= tail_r;
          if (push) begin
            tail_r <= push_data;
          end
        end
      end
    endcase
  end

endmodule

[design/apsp_dp.sv]
// Datapath: size register, distance matrix memory, loop counters and the
// relaxation add/compare. Driven by apsp_ctrl commands; uses apsp_pkg.
module apsp_dp
  import apsp_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [SIZE_W-1:0]   cfg_wdata,
  input  logic [IDX_W-1:0]    req_row,
  input  logic [IDX_W-1:0]    req_col,
  input  logic [WEIGHT_W-1:0] req_weight,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic                res_push,
  output result_t             res_data
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int CW    = (NW > IDX_W) ? NW : IDX_W;
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;

  logic [SIZE_W-1:0]   matrix_size_r;
  logic [NW-1:0]       n, n_m1;
  logic [VW-1:0]       k_r, i_r, j_r;
  logic [WEIGHT_W-1:0] via_r;
  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [WEIGHT_W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]       ra_a, ra_b, wa, req_addr, s1_addr_r;
  logic [WEIGHT_W-1:0] wd;
  logic                we, s1_valid_r, relax_we;
  logic [WEIGHT_W:0]   sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= SIZE_RESET;
    end else if (cfg_wen) begin
      matrix_size_r <= cfg_wdata;
    end
  end

  // clamp the size to the capacity
  always_comb begin
    if (int'(matrix_size_r) > MAX_VERTICES) begin
      n = NW'(MAX_VERTICES);
    end else begin
      n = NW'(matrix_size_r);
    end
  end

  assign n_m1        = n - NW'(1);
  assign sts.n_zero  = (n == NW'(0));
  assign sts.req_err = (CW'(req_row) >= CW'(n)) || (CW'(req_col) >= CW'(n));
  assign sts.j_last  = (j_r == VW'(n_m1));
  assign sts.i_last  = (i_r == VW'(n_m1));
  assign sts.k_last  = (k_r == VW'(n_m1));

  assign req_addr = {VW'(req_row), VW'(req_col)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        k_r <= '0;
        i_r <= '0;
      end else if (cmd.row_next) begin
        if (sts.i_last) begin
          i_r <= '0;
          k_r <= k_r + VW'(1);
        end else begin
          i_r <= i_r + VW'(1);
        end
      end
      if (cmd.via_ld) begin
        j_r <= '0;
      end else if (cmd.sweep) begin
        j_r <= j_r + VW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.via_ld) begin
      via_r <= rd_a_r;
    end
    s1_addr_r <= {i_r, j_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.sweep;
    end
  end

  always_comb begin
    if (cmd.req_rd) begin
      ra_a = req_addr;
    end else if (cmd.via_rd) begin
      ra_a = {i_r, k_r};
    end else begin
      ra_a = {i_r, j_r};
    end
  end
  assign ra_b = {k_r, j_r};

  // a(i,k) + a(k,j) against a(i,j), one entry a cycle
  assign sum      = {1'b0, via_r} + {1'b0, rd_b_r};
  assign relax_we = s1_valid_r && ({1'b0, rd_a_r} > sum);

  assign we = cmd.req_wr || relax_we;
  assign wa = cmd.req_wr ? req_addr : s1_addr_r;
  assign wd = cmd.req_wr ? req_weight : sum[WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  assign res_push             = cmd.push_zero || cmd.push_err || cmd.push_rd;
  assign res_data.index_error = cmd.push_err;
  assign res_data.read_value  = cmd.push_rd ? rd_a_r : '0;

endmodule

[design/apsp_ctrl.sv]
// Controller: request decode and the k/i/j sequencing of a closure run.
// Commands apsp_dp through dp_cmd_t; uses apsp_pkg.
module apsp_ctrl
  import apsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  req_type_t req_type,
  input  logic      q_full,
  input  dp_sts_t   sts,
  output logic      in_tready,
  output dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_VIA_RD,
    S_VIA_LD,
    S_SWEEP,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE) && !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_WRITE: begin
              cmd.req_wr    = !sts.req_err;
              cmd.push_err  = sts.req_err;
              cmd.push_zero = !sts.req_err;
            end
            REQ_READ: begin
              if (sts.req_err) begin
                cmd.push_err = 1'b1;
              end else begin
                cmd.req_rd = 1'b1;
                state_nxt  = S_RD_WAIT;
              end
            end
            REQ_RUN: begin
              if (sts.n_zero) begin
                cmd.push_zero = 1'b1;
              end else begin
                cmd.cnt_clr = 1'b1;
                state_nxt   = S_VIA_RD;
              end
            end
            default: begin
              cmd.push_zero = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.push_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_VIA_RD: begin
        cmd.via_rd = 1'b1;
        state_nxt  = S_VIA_LD;
      end
      S_VIA_LD: begin
        cmd.via_ld = 1'b1;
        state_nxt  = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.j_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last write of the row lands here; next row reads after it
        if (sts.i_last && sts.k_last) begin
          cmd.push_zero = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.row_next = 1'b1;
          state_nxt    = S_VIA_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/all_pairs_shortest_path.sv]
// All-pairs shortest path block: top level joining controller, datapath
// and result queue. Depends on apsp_pkg, apsp_ctrl, apsp_dp, apsp_outq.
//
// Holds a distance matrix of unsigned Q16.16 entries in a two-read,
// one-write memory; matrix_size (clamped to MAX_VERTICES) sets the square in
// use. Entries are undefined until written and there is no clearing pass:
// write every entry in use before a run. A write, or any request with a bad
// index, gives its result in the cycle it is taken; a valid read gives it
// from S_RD_WAIT, after the registered memory read. In a run, each row of each
// intermediate reads a(i,k), latches it, relaxes one entry a cycle through
// the single write port and then drains the last write. Every request gives
// one result; results wait in a two-entry queue, so a new request is taken
// while an earlier result is still unread, and a run's result appears once
// the matrix is final.
module all_pairs_shortest_path
  import apsp_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [SIZE_W-1:0]      cfg_wdata,    // matrix_size
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] req_type, [7:2] row, [13:8] col, [45:14] weight
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] read_value, [32] index_error
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  req_type_t req_type;
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      res_push, q_full;
  result_t   res_data, q_data;

  assign req_type = req_type_t'(in_tdata[REQ_W-1:0]);

  apsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (req_type),
    .q_full    (q_full),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  apsp_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .req_row    (in_tdata[ROW_LSB +: IDX_W]),
    .req_col    (in_tdata[COL_LSB +: IDX_W]),
    .req_weight (in_tdata[WEIGHT_LSB +: WEIGHT_W]),
    .cmd        (cmd),
    .sts        (sts),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  apsp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = {(OUT_TDATA_W - RES_W)'(0), q_data};

  // a result never arrives at a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !q_full)
    else $error("result pushed into full queue");

  // a write request answers in its own cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && req_type == REQ_WRITE) |-> res_push)
    else $error("write request gave no result");

  // a valid read answers in the next cycle, with no error flag
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && req_type == REQ_READ && !sts.req_err)
      |=> (res_push && !res_data.index_error))
    else $error("read request result missing");

endmodule

[tb/sv/apsp_checker.sv]
// Reply checker for the all-pairs shortest path block: watches the config
// port and both stream channels, predicts every reply and compares it.
// Depends on apsp_pkg.
module apsp_checker
  import apsp_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [SIZE_W-1:0]      cfg_wdata,      // matrix_size
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // [1:0] req_type, [7:2] row, [13:8] col, [45:14] weight
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] read_value, [32] index_error
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     pending_count,
  output int                     mismatch_count,
  output int                     checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WEIGHT_W-1:0] dist_q16 [MAX_VERTICES*MAX_VERTICES];
  int unsigned         vertices = MAX_VERTICES;
  result_t             predicted_replies [$];
  int                  misses = 0;
  int                  checks = 0;

  function automatic int unsigned cell_at(int unsigned r, int unsigned c);
    return r * MAX_VERTICES + c;
  endfunction

  // In-place closure, k outermost; sums carry one extra bit so they never wrap
  function automatic void relax_all_pairs();
    int unsigned       k;
    int unsigned       i;
    int unsigned       j;
    logic [WEIGHT_W:0] via;
    logic [WEIGHT_W:0] detour;
    for (k = 0; k < vertices; k++) begin
      for (i = 0; i < vertices; i++) begin
        via = {1'b0, dist_q16[cell_at(i, k)]};
        for (j = 0; j < vertices; j++) begin
          detour = via + {1'b0, dist_q16[cell_at(k, j)]};
          if ({1'b0, dist_q16[cell_at(i, j)]} > detour) begin
            dist_q16[cell_at(i, j)] = detour[WEIGHT_W-1:0];
          end
        end
      end
    end
  endfunction

  function automatic result_t serve_request(logic [IN_TDATA_W-1:0] item);
    req_type_t   kind;
    int unsigned r;
    int unsigned c;
    result_t     reply;
    kind  = req_type_t'(item[REQ_W-1:0]);
    r     = item[ROW_LSB +: IDX_W];
    c     = item[COL_LSB +: IDX_W];
    reply = '0;
    case (kind)
      REQ_WRITE, REQ_READ: begin
        if (r >= vertices || c >= vertices) begin
          reply.index_error = 1'b1;
        end else if (kind == REQ_WRITE) begin
          dist_q16[cell_at(r, c)] = item[WEIGHT_LSB +: WEIGHT_W];
        end else begin
          reply.read_value = dist_q16[cell_at(r, c)];
        end
      end
      REQ_RUN: relax_all_pairs();
      default: ;  // spare code: blank reply, matrix untouched
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin : track
    result_t seen;
    result_t want;
    if (!rst_n) begin
      predicted_replies.delete();
      vertices = (SIZE_RESET > MAX_VERTICES) ? MAX_VERTICES : SIZE_RESET;
      misses   = 0;
      checks   = 0;
    end else begin
      if (cfg_wen) begin
        vertices = (cfg_wdata > MAX_VERTICES) ? MAX_VERTICES : cfg_wdata;
      end
      // retire first: a reply never leaves on its own request's edge
      if (out_tvalid && out_tready) begin
        seen = result_t'(out_tdata[RES_W-1:0]);
        checks++;
        if (predicted_replies.size() == 0) begin
          misses++;
          $display("%0t apsp_checker: expected no reply, got value %h error %b",
                   $time, seen.read_value, seen.index_error);
        end else begin
          want = predicted_replies.pop_front();
          if (seen.read_value !== want.read_value) begin
            misses++;
            $display("%0t apsp_checker: read_value expected %h got %h",
                     $time, want.read_value, seen.read_value);
          end
          if (seen.index_error !== want.index_error) begin
            misses++;
            $display("%0t apsp_checker: index_error expected %b got %b",
                     $time, want.index_error, seen.index_error);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_replies.push_back(serve_request(in_tdata));
      end
    end
    pending_count  <= predicted_replies.size();
    mismatch_count <= misses;
    checked_count  <= checks;
  end

endmodule

[tb/sv/tb_all_pairs_shortest_path.sv]
// Testbench top for the all-pairs shortest path block: clock, reset, request
// stimulus with bursts and gaps, result back-pressure and the verdict.
// Depends on apsp_pkg, all_pairs_shortest_path and apsp_checker.
module tb_all_pairs_shortest_path;
  timeunit 1ns;
  timeprecision 1ps;
  import apsp_pkg::*;

  localparam int MAX_VERTICES  = 64;
  localparam int IDX_MAX       = MAX_VERTICES - 1;
  localparam int SIZE_MAX      = (1 << SIZE_W) - 1;
  localparam int RANDOM_ITEMS  = 650;
  localparam int MAX_CLOSURE_N = 9;
  localparam int QUIET_LIMIT   = 20000;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wen    = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata  = SIZE_RESET;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int outstanding;
  int mismatches;
  int checked;

  rx_mode_t    rx_mode    = RX_FREE;
  int          rx_span    = 0;
  int          burst_left = 0;
  int unsigned n_live     = MAX_VERTICES;
  bit          written_cell [MAX_VERTICES*MAX_VERTICES];
  int          n_writes    = 0;
  int          n_reads     = 0;
  int          n_runs      = 0;
  int          n_bad_index = 0;
  int          n_spare     = 0;
  int          n_sizes     = 0;

  always #2 clk = ~clk;

  all_pairs_shortest_path #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  apsp_checker #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .pending_count (outstanding),
    .mismatch_count(mismatches),
    .checked_count (checked)
  );

  // Receiver: free-flowing, coin-toss and mostly-stalled spans
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(RX_FREE, RX_SPARSE));
      rx_span <= $urandom_range(8, 64);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_FREE: out_tready <= 1'b1;
      RX_COIN: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("tb_all_pairs_shortest_path: FAIL");
    $finish;
  end

  function automatic bit in_square(int unsigned r, int unsigned c);
    return r < n_live && c < n_live;
  endfunction

  function automatic bit is_written(int unsigned r, int unsigned c);
    return written_cell[r * MAX_VERTICES + c];
  endfunction

  // Mostly small weights so paths actually shorten, plus values near the top
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3:    return $urandom;
      4:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  task automatic issue(input logic [REQ_W-1:0] req, input int unsigned r,
                       input int unsigned c, input logic [WEIGHT_W-1:0] w);
    int                    gap;
    logic [IN_TDATA_W-1:0] item;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= IN_TDATA_W'({$urandom, $urandom});
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item                        = '0;
    item[REQ_W-1:0]             = req;
    item[ROW_LSB +: IDX_W]      = r[IDX_W-1:0];
    item[COL_LSB +: IDX_W]      = c[IDX_W-1:0];
    item[WEIGHT_LSB +: WEIGHT_W] = w;
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    do @(posedge clk); while (in_tready !== 1'b1);
    case (req)
      REQ_WRITE, REQ_READ: begin
        if (!in_square(r, c)) n_bad_index++;
        else if (req == REQ_WRITE) written_cell[r * MAX_VERTICES + c] = 1'b1;
        if (req == REQ_WRITE) n_writes++;
        else n_reads++;
      end
      REQ_RUN: n_runs++;
      default: n_spare++;
    endcase
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned v);
    hold_until_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v[SIZE_W-1:0];
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    n_live = (v > MAX_VERTICES) ? MAX_VERTICES : v;
    n_sizes++;
  endtask

  // Noise: spare codes, indices off the square, reads of stored entries
  task automatic stray_item();
    int unsigned r;
    int unsigned c;
    r = $urandom_range(0, IDX_MAX);
    c = $urandom_range(0, IDX_MAX);
    case ($urandom_range(0, 2))
      0: issue(REQ_SPARE, r, c, $urandom);
      1: begin
        if (n_live < MAX_VERTICES) begin
          if ($urandom_range(0, 1) == 0) r = $urandom_range(n_live, IDX_MAX);
          else c = $urandom_range(n_live, IDX_MAX);
        end
        if (in_square(r, c) && !is_written(r, c)) issue(REQ_WRITE, r, c, pick_weight());
        else issue($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, r, c, pick_weight());
      end
      default: begin
        if (in_square(r, c) && !is_written(r, c)) issue(REQ_WRITE, r, c, pick_weight());
        else issue(REQ_READ, r, c, $urandom);
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned r;
    int unsigned c;
    int unsigned base;
    int          choice;
    int          rounds;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners of the full-size matrix and a spare code
    set_size(SIZE_RESET);
    issue(REQ_WRITE, 0, 0, '0);
    issue(REQ_WRITE, IDX_MAX, IDX_MAX, '1);
    issue(REQ_WRITE, 0, IDX_MAX, 32'h0001_0000);
    issue(REQ_WRITE, IDX_MAX, 0, 32'hAAAA_5555);
    issue(REQ_READ, 0, 0, '1);
    issue(REQ_READ, IDX_MAX, IDX_MAX, '0);
    issue(REQ_READ, 0, IDX_MAX, '0);
    issue(REQ_READ, IDX_MAX, 0, '0);
    issue(REQ_SPARE, IDX_MAX, IDX_MAX, '1);

    // Empty matrix: every access is out of range, a closure does nothing
    set_size(0);
    issue(REQ_WRITE, 0, 0, 32'h1234_5678);
    issue(REQ_READ, 0, 0, '0);
    issue(REQ_RUN, 0, 0, '0);

    // Oversized setting is held at capacity
    set_size(SIZE_MAX);
    issue(REQ_READ, IDX_MAX, IDX_MAX, '0);

    // Two vertices with sums that carry past 32 bits and must not relax
    set_size(2);
    issue(REQ_WRITE, 0, 0, 32'h0000_0020);
    issue(REQ_WRITE, 0, 1, 32'h0000_0010);
    issue(REQ_WRITE, 1, 0, 32'hFFFF_FFF0);
    issue(REQ_WRITE, 1, 1, 32'hFFFF_FFFF);
    issue(REQ_WRITE, 2, 0, '1);
    issue(REQ_READ, 0, 2, '0);
    issue(REQ_READ, IDX_MAX, 1, '0);
    issue(REQ_RUN, IDX_MAX, IDX_MAX, '1);
    issue(REQ_READ, 0, 0, '0);
    issue(REQ_READ, 0, 1, '0);
    issue(REQ_READ, 1, 0, '0);
    issue(REQ_READ, 1, 1, '0);

    base = n_writes + n_reads + n_runs;
    while (n_writes + n_reads + n_runs - base < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        // Fill the square, close it, read it back; sometimes patch and close again
        n = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, MAX_CLOSURE_N);
        set_size(n);
        for (r = 0; r < n; r++) begin
          for (c = 0; c < n; c++) begin
            if (!is_written(r, c) || $urandom_range(0, 3) != 0) begin
              issue(REQ_WRITE, r, c, pick_weight());
            end
            if ($urandom_range(0, 7) == 0) stray_item();
          end
        end
        rounds = $urandom_range(1, 2);
        repeat (rounds) begin
          issue(REQ_RUN, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX), $urandom);
          repeat (n * n / 2 + 2) begin
            if ($urandom_range(0, 9) == 0) stray_item();
            else issue(REQ_READ, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
          end
          repeat ($urandom_range(1, n)) begin
            issue(REQ_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight());
          end
        end
      end else if (choice < 9) begin
        // Large sizes: scattered accesses only, no closure
        set_size($urandom_range(MAX_CLOSURE_N + 1, SIZE_MAX));
        repeat ($urandom_range(15, 40)) begin
          r = $urandom_range(0, IDX_MAX);
          c = $urandom_range(0, IDX_MAX);
          if (in_square(r, c) && is_written(r, c) && $urandom_range(0, 1) == 0) begin
            issue(REQ_READ, r, c, $urandom);
          end else if (in_square(r, c)) begin
            issue(REQ_WRITE, r, c, pick_weight());
          end else begin
            issue($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, r, c, pick_weight());
          end
          if ($urandom_range(0, 5) == 0) stray_item();
        end
      end else begin
        set_size(0);
        repeat ($urandom_range(2, 6)) begin
          issue(REQ_W'($urandom_range(0, 3)), $urandom_range(0, IDX_MAX),
                $urandom_range(0, IDX_MAX), $urandom);
        end
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d writes, %0d reads, %0d closures, %0d out-of-range, %0d spare codes",
             n_writes, n_reads, n_runs, n_bad_index, n_spare);
    $display("over %0d size settings; %0d replies checked", n_sizes, checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_all_pairs_shortest_path: PASS");
    end else begin
      $display("tb_all_pairs_shortest_path: FAIL");
    end
    $finish;
  end

endmodule
